### hdl/obrr_pkg.sv
package obrr_pkg;

  // Run counter width; runs saturate at 2^COUNT_BITS - 1.
  localparam int COUNT_BITS = 16;

  localparam int RATIO_W  = 8;
  localparam int BCOUNT_W = 16;
  localparam int DVS_W    = RATIO_W + 1;     // divisor is 2 * ratio_halves
  localparam int DVD_W    = COUNT_BITS + 3;  // dividend is 4 * n + ratio_halves
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int SAT_W    = (DVD_W > BCOUNT_W) ? DVD_W : BCOUNT_W;

  localparam logic [RATIO_W-1:0]  RATIO_RESET = RATIO_W'(13);
  localparam logic [RATIO_W-1:0]  RATIO_MIN   = RATIO_W'(2);
  localparam logic [COUNT_BITS-1:0] RUN_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [BCOUNT_W-1:0] BCOUNT_MAX  = {BCOUNT_W{1'b1}};

  // APB register map
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_RATIO_HALVES = 1'b0;  // register index, paddr[2]

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAN,
    ST_DIV_A,
    ST_DIV_B,
    ST_EMIT_A,
    ST_EMIT_B
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel_b;
    logic out_load;
    logic out_sel_b;
    logic out_last;
    logic out_done;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_a;
    logic need_b;
    logic eos;
    logic div_done;
    logic a_nz;
    logic b_nz;
    logic out_free;
  } dp_stat_t;

  // Clip a quotient to the bit count range.
  function automatic logic [BCOUNT_W-1:0] sat_count(input logic [DVD_W-1:0] q);
    logic [SAT_W-1:0] qx;
    qx = SAT_W'(q);
    if (qx > SAT_W'(BCOUNT_MAX)) begin
      return BCOUNT_MAX;
    end
    return qx[BCOUNT_W-1:0];
  endfunction

endpackage

### hdl/obrr_if.sv
interface obrr_in_if;
  logic valid;
  logic ready;
  logic sample_bit;
  logic end_of_stream;

  modport source(output valid, sample_bit, end_of_stream, input ready);
  modport sink(input valid, sample_bit, end_of_stream, output ready);
endinterface

interface obrr_out_if import obrr_pkg::*;;
  logic                valid;
  logic                ready;
  logic                bit_value;
  logic [BCOUNT_W-1:0] bit_count;
  logic                last_of_item;
  logic                stream_done;

  modport source(output valid, bit_value, bit_count, last_of_item, stream_done,
                 input ready);
  modport sink(input valid, bit_value, bit_count, last_of_item, stream_done,
               output ready);
endinterface

### hdl/oversampled_bit_run_recovery.sv
// Oversampled run-length bit recovery. Each input beat carries one line
// sample and an end-of-stream flag. Runs of equal samples are counted; the
// first run of a stream is dropped. When the level changes, the finished run
// of n samples is turned into round(n / ratio) bits, ratio = ratio_halves / 2,
// computed exactly as floor((4n + ratio_halves) / (2 * ratio_halves)), and a
// non-empty run leaves as one output beat (level, bit count). On end of
// stream the open run is flushed too and the run state clears; ratio_halves
// (APB offset 0x0, reset 13 = 6.5 samples/bit, values 0 and 1 act as 2) keeps
// its value. A sample that closes no run passes only accept (IDLE) and PLAN.
// A run that closes goes through one shared restoring divider that makes one
// quotient bit per cycle (COUNT_BITS + 3 = 19 steps); an end-of-stream
// sample that closes two runs has them divided one after the other.
// The output register lets the next sample be accepted while the last result
// beat still waits for out_ch.ready. Write ratio_halves only when idle.
module oversampled_bit_run_recovery import obrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  obrr_in_if.sink               in_ch,
  obrr_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [RATIO_W-1:0] ratio_r;
  logic               cfg_wr;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  // APB: zero wait states; register index is paddr[2], other indexes ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
    end else if (cfg_wr && (paddr[2] == REG_RATIO_HALVES)) begin
      ratio_r <= pwdata[RATIO_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RATIO_HALVES) ? CFG_DATA_W'(ratio_r) : '0;

  obrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  obrr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .ratio_halves  (ratio_r),
    .in_sample     (in_ch.sample_bit),
    .in_eos        (in_ch.end_of_stream),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_bit_value (out_ch.bit_value),
    .out_bit_count (out_ch.bit_count),
    .out_last      (out_ch.last_of_item),
    .out_done      (out_ch.stream_done)
  );

endmodule

### hdl/obrr_div.sv
module obrr_div import obrr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  // Restoring divider, one quotient bit per cycle. Quotient bits shift into
  // the dividend register from the bottom.
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           ge;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DVD_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    ge       = (rem_sh >= {1'b0, dvs_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

### hdl/obrr_dp.sv
module obrr_dp import obrr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [RATIO_W-1:0]  ratio_halves,
  input  logic                in_sample,
  input  logic                in_eos,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_bit_value,
  output logic [BCOUNT_W-1:0] out_bit_count,
  output logic                out_last,
  output logic                out_done
);

  // open run
  logic                  seen_r, seen_nxt;
  logic                  skip_r, skip_nxt;
  logic                  level_r, level_nxt;
  logic [COUNT_BITS-1:0] len_r, len_nxt;

  // item snapshot: run closed by a level change (a), run closed by end of stream (b)
  logic                  a_level_r, b_level_r;
  logic [COUNT_BITS-1:0] a_len_r, b_len_r;
  logic                  need_a_r, need_b_r, eos_r;
  logic [BCOUNT_W-1:0]   a_cnt_r, b_cnt_r;
  logic                  div_sel_r;

  logic                  out_valid_r;
  logic                  out_value_r, out_last_r, out_done_r;
  logic [BCOUNT_W-1:0]   out_count_r;

  logic                  change;
  logic                  upd_level, upd_skip;
  logic [COUNT_BITS-1:0] upd_len;
  logic [RATIO_W-1:0]    rh;
  logic [COUNT_BITS-1:0] div_len;
  logic [DVD_W-1:0]      dividend;
  logic [DVS_W-1:0]      divisor;
  logic                  div_done;
  logic [DVD_W-1:0]      quotient;
  logic [BCOUNT_W-1:0]   q_sat;

  always_comb begin
    change    = seen_r && (in_sample != level_r);
    upd_level = in_sample;
    upd_len   = COUNT_BITS'(1);
    upd_skip  = skip_r;
    if (seen_r && !change) begin
      upd_level = level_r;
      upd_len   = (len_r == RUN_MAX) ? len_r : len_r + COUNT_BITS'(1);
    end else if (change) begin
      upd_skip = 1'b0;
    end
    if (in_eos) begin
      seen_nxt  = 1'b0;
      skip_nxt  = 1'b1;
      level_nxt = 1'b0;
      len_nxt   = '0;
    end else begin
      seen_nxt  = 1'b1;
      skip_nxt  = upd_skip;
      level_nxt = upd_level;
      len_nxt   = upd_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      skip_r   <= 1'b1;
      level_r  <= 1'b0;
      len_r    <= '0;
      need_a_r <= 1'b0;
      need_b_r <= 1'b0;
      eos_r    <= 1'b0;
    end else if (cmd.accept) begin
      seen_r   <= seen_nxt;
      skip_r   <= skip_nxt;
      level_r  <= level_nxt;
      len_r    <= len_nxt;
      need_a_r <= change && !skip_r;
      need_b_r <= in_eos && !upd_skip;
      eos_r    <= in_eos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_level_r <= level_r;
      a_len_r   <= len_r;
      b_level_r <= upd_level;
      b_len_r   <= upd_len;
    end
  end

  // rounding divide: floor((4n + rh) / (2 rh))
  assign rh       = (ratio_halves < RATIO_MIN) ? RATIO_MIN : ratio_halves;
  assign div_len  = cmd.div_sel_b ? b_len_r : a_len_r;
  assign dividend = DVD_W'({div_len, 2'b00}) + DVD_W'(rh);
  assign divisor  = {rh, 1'b0};

  obrr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_sat = sat_count(quotient);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel_b;
    end
    if (div_done) begin
      if (div_sel_r) begin
        b_cnt_r <= q_sat;
      end else begin
        a_cnt_r <= q_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= cmd.out_sel_b ? b_level_r : a_level_r;
      out_count_r <= cmd.out_sel_b ? b_cnt_r : a_cnt_r;
      out_last_r  <= cmd.out_last;
      out_done_r  <= cmd.out_done;
    end
  end

  always_comb begin
    stat.need_a   = need_a_r;
    stat.need_b   = need_b_r;
    stat.eos      = eos_r;
    stat.div_done = div_done;
    stat.a_nz     = (a_cnt_r != '0);
    stat.b_nz     = (b_cnt_r != '0);
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_bit_value = out_value_r;
  assign out_bit_count = out_count_r;
  assign out_last      = out_last_r;
  assign out_done      = out_done_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");

  a_b_needs_eos: assert property (@(posedge clk) disable iff (!rst_n)
    need_b_r |-> eos_r)
    else $error("end-of-stream run pending without end of stream");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (len_r != '0))
    else $error("open run has zero length");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("stream_done on a beat that is not last of item");

endmodule

### hdl/obrr_ctrl.sv
module obrr_ctrl import obrr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        has_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    has_b     = stat.need_b && stat.b_nz;
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PLAN;
        end
      end
      ST_PLAN: begin
        if (stat.need_a) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV_A;
        end else if (stat.need_b) begin
          cmd.div_start = 1'b1;
          cmd.div_sel_b = 1'b1;
          state_nxt     = ST_DIV_B;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV_A: begin
        if (stat.div_done) begin
          if (stat.need_b) begin
            cmd.div_start = 1'b1;
            cmd.div_sel_b = 1'b1;
            state_nxt     = ST_DIV_B;
          end else begin
            state_nxt = ST_EMIT_A;
          end
        end
      end
      ST_DIV_B: begin
        if (stat.div_done) begin
          state_nxt = stat.need_a ? ST_EMIT_A : ST_EMIT_B;
        end
      end
      ST_EMIT_A: begin
        if (!stat.a_nz) begin
          state_nxt = stat.need_b ? ST_EMIT_B : ST_IDLE;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = !has_b;
          cmd.out_done = stat.eos && !has_b;
          state_nxt    = stat.need_b ? ST_EMIT_B : ST_IDLE;
        end
      end
      ST_EMIT_B: begin
        if (!stat.b_nz) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel_b = 1'b1;
          cmd.out_last  = 1'b1;
          cmd.out_done  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_plans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_PLAN))
    else $error("accepted sample not followed by planning");

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !stat.div_done)
    else $error("divider finished in one cycle");

  a_emit_b_eos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_sel_b) |-> stat.eos)
    else $error("end-of-stream run emitted without end of stream");

endmodule
